@@ hdl/sfpr_pkg.sv @@
// ----------------------------------------------------------------------------
// sfpr_pkg
// Types and constants used by the serial frame parser.
// ----------------------------------------------------------------------------
package sfpr_pkg;

	localparam int MAX_PAYLOAD = 64;
	localparam int STORE_DEPTH = 70;
	localparam int ADDR_W      = 7;
	localparam int RAM_DEPTH   = 1 << ADDR_W;
	localparam int MAX_RESULTS = 40;

	localparam logic [7:0] HDR0 = 8'h57;
	localparam logic [7:0] HDR1 = 8'hAB;
	localparam logic [6:0] DROP_HDR    = 7'd2;
	localparam logic [6:0] LEN_POS     = 7'd4;
	localparam logic [6:0] FRAME_EXTRA = 7'd6;
	localparam logic [31:0] TIMEOUT_RESET = 32'd50;

	localparam logic [1:0] KIND_GOOD    = 2'd0;
	localparam logic [1:0] KIND_BADSUM  = 2'd1;
	localparam logic [1:0] KIND_TIMEOUT = 2'd2;

	typedef struct packed {
		logic        func;
		logic [7:0]  rx_byte;
		logic [31:0] now_time;
	} in_t;

	typedef struct packed {
		logic [1:0]  event_kind;
		logic [7:0]  frame_address;
		logic [7:0]  frame_command;
		logic [6:0]  payload_length;
		logic [6:0]  bytes_held;
		logic [2:0]  word_number;
		logic [63:0] payload_word;
		logic        run_end;
	} out_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_POLL, ST_TB, ST_TC, ST_BYTE, ST_SCAN, ST_R0, ST_R1,
		ST_AL, ST_H2, ST_H3, ST_H4, ST_SUM, ST_CHK, ST_PWD, ST_SEND
	} state_t;

endpackage

@@ hdl/sfpr_ram.sv @@
// ----------------------------------------------------------------------------
// sfpr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port, holds while idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hdl/serial_frame_parser_resync.sv @@
// Flow: a poll checks only the timeout; a stored byte starts a rescan from the buffer
//   head, and a frame found whole is summed byte by byte, then read out per payload byte.
// Throughput: one transaction at a time; the one-read-per-cycle frame RAM
//   port sets the pace of every rescan and checksum pass.
// Reset: asynchronous; buffer empty, last byte time 0, timeout limit 50.
// ----------------------------------------------------------------------------
// serial_frame_parser_resync
// Buffers 57 AB framed packets in a circular RAM, checks the byte-sum
// checksum, reports frames eight payload bytes per result, and expires
// partial frames after a silence timeout with header-drop resync.
// ----------------------------------------------------------------------------
module serial_frame_parser_resync
	import sfpr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_t        out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	state_t state_q, state_d;

	in_t          item_q;
	logic [31:0]  limit_q, last_q;
	logic [ADDR_W-1:0] head_q;
	logic [6:0]   fill_q, tot_q, len_q, j_q, p_q;
	logic [7:0]   addr_q, cmd_q, sum_q;
	logic [63:0]  word_q;
	logic         phase_q;
	logic         pend_v_q, out_v_q;
	out_t         pend_q, out_q;
	logic [5:0]   rcnt_q;

	logic [7:0]   rd;
	logic         re, we;
	logic [6:0]   rd_off, drop_n;
	logic [ADDR_W-1:0] raddr, waddr;
	logic         emit_req, adv, can_push, cnt_full, tmo, take;
	logic         emit_go, last_go;
	out_t         emit_res;
	logic [6:0]   fill_eff;
	logic [63:0]  word_nx;
	logic         word_end;

	sfpr_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (item_q.rx_byte),
		.re    (re),
		.raddr (raddr),
		.rdata (rd)
	);

	// handshake side
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign out_valid = out_v_q;
	assign out_data  = out_q;
	assign can_push  = !out_v_q || !out_stall;
	assign cnt_full  = (rcnt_q >= 6'(MAX_RESULTS));

	// poll and byte decisions
	assign tmo = (fill_q != 7'd0) && ((item_q.now_time - last_q) >= limit_q);
	always_comb begin
		take     = 1'b1;
		fill_eff = fill_q;
		if (fill_q == 7'd0 && item_q.rx_byte != HDR0) begin
			take = 1'b0;
		end else if (fill_q >= 7'(STORE_DEPTH)) begin
			fill_eff = 7'd0;
			take     = (item_q.rx_byte == HDR0);
		end
	end

	// payload word with the current byte merged in
	always_comb begin
		word_nx = word_q;
		word_nx[{p_q[2:0], 3'b000} +: 8] = rd;
	end
	assign word_end = (p_q[2:0] == 3'd7) || (p_q + 7'd1 == len_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_POLL;
			ST_POLL: begin
				if (tmo) state_d = ST_TB;
				else if (item_q.func) state_d = ST_IDLE;
				else state_d = ST_BYTE;
			end
			ST_TB:   state_d = ST_TC;
			ST_TC:   if (adv) state_d = ST_SCAN;
			ST_BYTE: state_d = take ? ST_SCAN : ST_SEND;
			ST_SCAN: state_d = (fill_q == 7'd0) ? ST_SEND : ST_R0;
			ST_R0: begin
				if (rd != HDR0) state_d = ST_SCAN;
				else if (fill_q < 7'd2) state_d = ST_AL;
				else state_d = ST_R1;
			end
			ST_R1:   state_d = (rd != HDR1) ? ST_SCAN : ST_AL;
			ST_AL:   state_d = (fill_q < LEN_POS + 7'd1) ? ST_SEND : ST_H2;
			ST_H2:   state_d = ST_H3;
			ST_H3:   state_d = ST_H4;
			ST_H4: begin
				if (rd > 8'(MAX_PAYLOAD)) state_d = ST_SCAN;
				else if (fill_q < rd[6:0] + FRAME_EXTRA) state_d = ST_SEND;
				else state_d = ST_SUM;
			end
			ST_SUM:  if (j_q == tot_q - 7'd2) state_d = ST_CHK;
			ST_CHK: begin
				if (adv) begin
					if (sum_q == rd && len_q != 7'd0) state_d = ST_PWD;
					else state_d = ST_SCAN;
				end
			end
			ST_PWD:  if (adv && p_q + 7'd1 == len_q) state_d = ST_SCAN;
			ST_SEND: begin
				// end of scan; after a timeout scan a byte goes on to ST_BYTE, else the final pending result goes out here
				if (phase_q == 1'b0 && !item_q.func) state_d = ST_BYTE;
				else if (adv) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// RAM controls, result emission and drops
	always_comb begin
		re       = 1'b0;
		rd_off   = 7'd0;
		we       = 1'b0;
		drop_n   = 7'd0;
		emit_req = 1'b0;
		emit_res = '0;
		adv      = 1'b1;
		unique case (state_q)
			ST_POLL: if (tmo) begin re = 1'b1; rd_off = 7'd2; end
			ST_TB: begin re = 1'b1; rd_off = 7'd3; end
			ST_TC: begin
				emit_req = 1'b1;
				emit_res.event_kind    = KIND_TIMEOUT;
				emit_res.frame_address = addr_q;
				emit_res.frame_command = (fill_q >= 7'd4) ? rd : 8'd0;
				emit_res.bytes_held    = fill_q;
				drop_n = (fill_q >= DROP_HDR) ? DROP_HDR : fill_q;
			end
			ST_BYTE: we = take;
			ST_SCAN: if (fill_q != 7'd0) begin re = 1'b1; rd_off = 7'd0; end
			ST_R0: begin
				if (rd != HDR0) drop_n = 7'd1;
				else if (fill_q >= 7'd2) begin re = 1'b1; rd_off = 7'd1; end
			end
			ST_R1: if (rd != HDR1) drop_n = 7'd1;
			ST_AL: begin re = 1'b1; rd_off = 7'd2; end
			ST_H2: begin re = 1'b1; rd_off = 7'd3; end
			ST_H3: begin re = 1'b1; rd_off = LEN_POS; end
			ST_H4: begin
				if (rd > 8'(MAX_PAYLOAD)) drop_n = DROP_HDR;
				else begin re = 1'b1; rd_off = 7'd0; end
			end
			ST_SUM: begin
				re     = 1'b1;
				rd_off = (j_q == tot_q - 7'd2) ? tot_q - 7'd1 : j_q + 7'd1;
			end
			ST_CHK: begin
				emit_res.frame_address  = addr_q;
				emit_res.frame_command  = cmd_q;
				emit_res.payload_length = len_q;
				emit_res.bytes_held     = tot_q;
				if (sum_q != rd) begin
					emit_req = 1'b1;
					emit_res.event_kind = KIND_BADSUM;
					drop_n = DROP_HDR;
				end else if (len_q == 7'd0) begin
					emit_req = 1'b1;
					emit_res.event_kind = KIND_GOOD;
					drop_n = tot_q;
				end else begin
					re = 1'b1; rd_off = 7'd5;
				end
			end
			ST_PWD: begin
				emit_req = word_end;
				emit_res.event_kind     = KIND_GOOD;
				emit_res.frame_address  = addr_q;
				emit_res.frame_command  = cmd_q;
				emit_res.payload_length = len_q;
				emit_res.bytes_held     = tot_q;
				emit_res.word_number    = p_q[5:3];
				emit_res.payload_word   = word_nx;
				if (p_q + 7'd1 == len_q) drop_n = tot_q;
				else begin re = 1'b1; rd_off = p_q + 7'd6; end
			end
			ST_SEND: if (!(phase_q == 1'b0 && !item_q.func)) adv = !pend_v_q || can_push;
			default: ;
		endcase
		if (emit_req) adv = cnt_full || !pend_v_q || can_push;
		if (!adv) begin
			re     = 1'b0;
			drop_n = 7'd0;
		end
	end

	assign raddr = head_q + rd_off;
	assign waddr = head_q + fill_eff;

	// result slot moves
	assign emit_go = emit_req && adv && !cnt_full;
	assign last_go = (state_q == ST_SEND) && (state_d == ST_IDLE) && pend_v_q;

	// control and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			limit_q  <= TIMEOUT_RESET;
			last_q   <= '0;
			head_q   <= '0;
			fill_q   <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
			rcnt_q   <= '0;
			phase_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) limit_q <= cfg_data;

			// output register loads on a push, drains when taken
			if ((emit_go && pend_v_q) || last_go) out_v_q <= 1'b1;
			else if (out_v_q && !out_stall) out_v_q <= 1'b0;

			// one-deep pending slot: a new result pushes the older one out
			if (emit_go) pend_v_q <= 1'b1;
			else if (last_go) pend_v_q <= 1'b0;

			// results of the current transaction
			if (state_q == ST_IDLE && in_valid) rcnt_q <= '0;
			else if (emit_go) rcnt_q <= rcnt_q + 6'd1;

			// buffer pointers
			head_q <= head_q + drop_n;
			if (state_q == ST_BYTE) fill_q <= take ? fill_eff + 7'd1 : fill_eff;
			else if (state_q == ST_SEND && phase_q == 1'b0) fill_q <= '0;
			else fill_q <= (drop_n >= fill_q) ? 7'd0 : fill_q - drop_n;

			unique case (state_q)
				ST_POLL: phase_q <= 1'b0;
				ST_BYTE: begin
					last_q  <= item_q.now_time;
					phase_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) item_q <= in_data;
		if (emit_go) begin
			pend_q <= emit_res;
			if (pend_v_q) out_q <= pend_q;
		end else if (last_go) begin
			out_q <= {pend_q[$bits(out_t)-1:1], 1'b1};
		end
		unique case (state_q)
			ST_TB: addr_q <= (fill_q >= 7'd3) ? rd : 8'd0;
			ST_H2: addr_q <= rd;
			ST_H3: cmd_q  <= rd;
			ST_H4: begin
				len_q <= rd[6:0];
				tot_q <= rd[6:0] + FRAME_EXTRA;
				j_q   <= '0;
				sum_q <= '0;
			end
			ST_SUM: begin
				sum_q <= sum_q + rd;
				j_q   <= j_q + 7'd1;
			end
			ST_CHK: begin
				p_q    <= '0;
				word_q <= '0;
			end
			ST_PWD: if (adv) begin
				p_q    <= p_q + 7'd1;
				word_q <= word_end ? 64'd0 : word_nx;
			end
			default: ;
		endcase
	end

`ifndef SYNTH
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 7'(STORE_DEPTH))
		else $error("buffer fill beyond store depth");
	a_rcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rcnt_q <= 6'(MAX_RESULTS))
		else $error("result count beyond limit");
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pend_v_q)
		else $error("pending result left at idle");
	a_push_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEND && state_d == ST_IDLE && pend_v_q |=> out_v_q && out_q.run_end)
		else $error("final result not marked");
`endif

endmodule
